// ----- rtl/core/bbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared widths, register codes and control/status types of the box blur.
// ----------------------------------------------------------------------------
package bbf_pkg;

	// Fixed field widths
	localparam int BYTE_W   = 8;
	localparam int KW       = 4;   // kernel_size register
	localparam int MW       = 3;   // window margin (K-1)/2
	localparam int ROW_W    = 13;  // row_count register and row counters
	localparam int CFG_W    = 13;  // widest register
	localparam int CFG_IW   = 2;   // register index
	localparam int SUM_W    = 16;  // window sum, up to 225 * 255
	localparam int DIV_W    = 8;   // divisor K*K, up to 225
	localparam int STEP_W   = 4;   // divider step count
	localparam int MAX_ROWS = 4096;

	// Parameter defaults
	localparam int DEF_MAX_KERNEL     = 15;
	localparam int DEF_MAX_LINE_BYTES = 4096;

	// Register indexes
	localparam logic [CFG_IW-1:0] REG_KERNEL = 2'd0;
	localparam logic [CFG_IW-1:0] REG_LINE   = 2'd1;
	localparam logic [CFG_IW-1:0] REG_ROWS   = 2'd2;

	// Register reset values
	localparam logic [KW-1:0]    RST_KERNEL = 4'd3;
	localparam logic [CFG_W-1:0] RST_LINE   = 13'd1920;
	localparam logic [ROW_W-1:0] RST_ROWS   = 13'd480;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;    // input transfer this cycle
		logic win_load;  // set up window walk
		logic rd;        // issue one history read
		logic div_load;  // load divider
		logic div_step;  // one quotient bit
		logic put;       // load output register
	} bbf_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic emit;      // current input item causes a result
		logic rd_last;   // this read is the last of the window
		logic div_last;  // this step is the last quotient bit
		logic out_free;  // output register can take a result
	} bbf_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/bbf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/bbf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_ctrl
// Sequencer: takes an item, walks the window, runs the divider, hands over.
// ----------------------------------------------------------------------------
module bbf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire bbf_pkg::bbf_sts_t sts,
	output bbf_pkg::bbf_cmd_t      cmd
);
	import bbf_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_DLOAD = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && sts.emit) begin
					cmd.win_load = 1'b1;
					state_d      = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				if (sts.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (sts.out_free) begin
					cmd.put = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/bbf_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbf_dp
// Datapath: registers, position counters, row history, window sum, divider
// and output register.
// ----------------------------------------------------------------------------
module bbf_dp #(
	parameter int MAX_KERNEL     = 15,
	parameter int MAX_LINE_BYTES = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write,
	input  wire logic [bbf_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [bbf_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        action,
	input  wire logic [bbf_pkg::BYTE_W-1:0]  pixel_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [bbf_pkg::BYTE_W-1:0]  value,
	output logic                             last,
	input  wire bbf_pkg::bbf_cmd_t           cmd,
	output bbf_pkg::bbf_sts_t                sts
);
	import bbf_pkg::*;

	localparam int SW    = $clog2(MAX_KERNEL);
	localparam int CW    = $clog2(MAX_LINE_BYTES);
	localparam int LW    = $clog2(MAX_LINE_BYTES + 1);
	localparam int DEPTH = MAX_KERNEL * MAX_LINE_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = LW + ROW_W;
	localparam logic [AW-1:0] LINE_A = AW'(MAX_LINE_BYTES);

	// Configuration registers
	logic [KW-1:0]    kernel_q;
	logic [CFG_W-1:0] line_q;
	logic [ROW_W-1:0] rows_q;

	// Effective settings
	logic [KW-1:0]    k_eff;
	logic [MW-1:0]    m;
	logic [LW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [PW-1:0]    lag;

	// Position state
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [CW-1:0]    in_col_q, out_col_q;
	logic [SW-1:0]    in_slot_q, out_slot_q;
	logic [PW-1:0]    pend_q;
	logic             in_done;
	logic             interior;
	logic             last_pos;
	logic             restart;

	// Window walk
	logic [SW-1:0] it_slot_q;
	logic [CW-1:0] it_col_q, col_base_q;
	logic [KW-1:0] ri_q, ci_q, span_q;
	logic [SW:0]   start_slot;
	logic          rd_s1;
	logic [SUM_W-1:0] acc_q;

	// Divider
	logic [DIV_W-1:0]  dvs_q, rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W:0]    trial;
	logic              fits;

	// Memory ports
	logic              mem_we;
	logic [AW-1:0]     waddr, raddr;
	logic [BYTE_W-1:0] rdata;

	// Clamp the register values
	always_comb begin
		if (kernel_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(kernel_q) > MAX_KERNEL) begin
			k_eff = KW'(MAX_KERNEL);
		end else begin
			k_eff = kernel_q;
		end
		if (line_q == '0) begin
			w_eff = LW'(1);
		end else if (32'(line_q) > MAX_LINE_BYTES) begin
			w_eff = LW'(MAX_LINE_BYTES);
		end else begin
			w_eff = LW'(line_q);
		end
		if (rows_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			h_eff = ROW_W'(MAX_ROWS);
		end else begin
			h_eff = rows_q;
		end
	end

	assign m   = MW'((k_eff - KW'(1)) >> 1);
	assign lag = PW'(m) * PW'(w_eff) + PW'(m);

	assign in_done  = (in_row_q == h_eff);
	assign interior = (out_row_q >= ROW_W'(m))
		&& ((ROW_W+1)'(out_row_q) + (ROW_W+1)'(m) < (ROW_W+1)'(h_eff))
		&& (out_col_q >= CW'(m))
		&& ((LW+1)'(out_col_q) + (LW+1)'(m) < (LW+1)'(w_eff));
	assign last_pos = (out_row_q == h_eff - ROW_W'(1))
		&& (out_col_q == CW'(w_eff - LW'(1)));
	assign restart  = cmd.put && last_pos;

	// Decide whether the offered item gives a result, and derive the other status flags
	always_comb begin
		sts.emit     = action ? in_done : (!in_done && (pend_q >= lag));
		sts.rd_last  = (ri_q == span_q) && (ci_q == span_q);
		sts.div_last = (step_q == STEP_W'(SUM_W - 1));
		sts.out_free = !out_valid || !out_stall;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= RST_KERNEL;
			line_q   <= RST_LINE;
			rows_q   <= RST_ROWS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KERNEL: kernel_q <= cfg_data[KW-1:0];
				REG_LINE:   line_q   <= cfg_data;
				REG_ROWS:   rows_q   <= cfg_data[ROW_W-1:0];
				default:    ;
			endcase
		end
	end

	// Position counters; a config write or the final result restarts the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else if (cfg_write || restart) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else begin
			if (mem_we) begin
				pend_q <= pend_q + PW'(1);
				if (in_col_q == CW'(w_eff - LW'(1))) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + ROW_W'(1);
					in_slot_q <= (in_slot_q == SW'(MAX_KERNEL - 1)) ? '0
						: in_slot_q + SW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (cmd.put) begin
				pend_q <= pend_q - PW'(1);
				if (out_col_q == CW'(w_eff - LW'(1))) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + ROW_W'(1);
					out_slot_q <= (out_slot_q == SW'(MAX_KERNEL - 1)) ? '0
						: out_slot_q + SW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// Store accepted bytes
	assign mem_we = cmd.accept && !action && !in_done;
	assign waddr  = AW'(in_slot_q) * LINE_A + AW'(in_col_q);
	assign raddr  = AW'(it_slot_q) * LINE_A + AW'(it_col_q);

	bbf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (mem_we),
		.waddr(waddr),
		.wdata(pixel_byte),
		.re   (cmd.rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	// First history row of the window, wrapped round the row slots
	assign start_slot = (out_slot_q >= SW'(m))
		? (SW+1)'(out_slot_q) - (SW+1)'(m)
		: (SW+1)'(out_slot_q) + (SW+1)'(MAX_KERNEL) - (SW+1)'(m);

	// Walk the window row by row
	always_ff @(posedge clk) begin
		if (cmd.win_load) begin
			ri_q <= '0;
			ci_q <= '0;
			if (interior) begin
				span_q     <= KW'(m) << 1;
				it_slot_q  <= SW'(start_slot);
				it_col_q   <= out_col_q - CW'(m);
				col_base_q <= out_col_q - CW'(m);
			end else begin
				span_q     <= '0;
				it_slot_q  <= out_slot_q;
				it_col_q   <= out_col_q;
				col_base_q <= out_col_q;
			end
		end else if (cmd.rd) begin
			if (ci_q == span_q) begin
				ci_q      <= '0;
				ri_q      <= ri_q + KW'(1);
				it_col_q  <= col_base_q;
				it_slot_q <= (it_slot_q == SW'(MAX_KERNEL - 1)) ? '0
					: it_slot_q + SW'(1);
			end else begin
				ci_q     <= ci_q + KW'(1);
				it_col_q <= it_col_q + CW'(1);
			end
		end
	end

	// Track read data in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
		end
	end

	// Accumulate the window sum
	always_ff @(posedge clk) begin
		if (cmd.win_load) begin
			acc_q <= '0;
		end else if (rd_s1) begin
			acc_q <= acc_q + SUM_W'(rdata);
		end
	end

	// Restoring divider, one quotient bit a cycle; border bytes divide by one
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q  <= acc_q;
			rem_q  <= '0;
			step_q <= '0;
			dvs_q  <= interior ? DIV_W'(k_eff) * DIV_W'(k_eff) : DIV_W'(1);
		end else if (cmd.div_step) begin
			rem_q  <= fits ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
			quo_q  <= {quo_q[SUM_W-2:0], fits};
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.put) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			value <= quo_q[BYTE_W-1:0];
			last  <= last_pos;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/box_blur_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_filter
// Streaming K x K mean filter over raster-order image bytes, with bytes near
// the edges passed through unchanged.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | in_valid/in_stall  | action, pixel_byte
//  output  | out       | out_valid/out_stall| value, last
//  config  | in        | cfg_write          | cfg_index, cfg_data
//
//  An item with no result is taken in the idle state. An item with a result
//  walks the window (only the byte itself at a border byte), reading one
//  window byte per cycle on the single read port of the row history, then
//  runs the bit-serial divider. A waiting result does not block the
//  next input; a stalled output holds the following result in the sequencer.
//  Reset restores the register defaults and restarts the image.
// ----------------------------------------------------------------------------
module box_blur_filter #(
	parameter int MAX_KERNEL     = bbf_pkg::DEF_MAX_KERNEL,
	parameter int MAX_LINE_BYTES = bbf_pkg::DEF_MAX_LINE_BYTES
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [bbf_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [bbf_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       action,
	input  wire logic [bbf_pkg::BYTE_W-1:0] pixel_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [bbf_pkg::BYTE_W-1:0] value,
	output logic                            last
);
	import bbf_pkg::*;

	bbf_cmd_t cmd;
	bbf_sts_t sts;

	// Sequencer
	bbf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath
	bbf_dp #(
		.MAX_KERNEL    (MAX_KERNEL),
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.action    (action),
		.pixel_byte(pixel_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts)
	);

	// A result only appears after a hand-over from the sequencer
	a_rise_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.put))
		else $error("output valid without a hand-over");

	// Hand-over never overwrites a stalled result
	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

	// No input transfer while the window is being read
	a_rd_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> in_stall)
		else $error("input taken during window read");

endmodule
`default_nettype wire
